// ===== hw/rtl/gda_pkg.sv =====
// Shared types, constants and calendar helpers for the Gregorian date unit.
// No dependencies; every other source file uses this package.
package gda_pkg;

    // Design sizing
    localparam int YEAR_BITS  = 16;   // working year range 0 .. 2^YEAR_BITS-1 (12..32)
    localparam int COUNT_BITS = 16;   // used low bits of day_count (8..24)

    // Fixed field widths of the channels
    localparam int KIND_BITS   = 3;
    localparam int DAY_BITS    = 5;
    localparam int MONTH_BITS  = 4;
    localparam int FYEAR_BITS  = 16;
    localparam int FCOUNT_BITS = 16;
    localparam int STATUS_BITS = 2;

    // Day count bits that can actually reach the datapath
    localparam int CNT_USE_BITS = (COUNT_BITS < FCOUNT_BITS) ? COUNT_BITS : FCOUNT_BITS;
    // Signed working day: 31 + max count, or 1 - max count
    localparam int WDAY_BITS = CNT_USE_BITS + 2;

    localparam logic [YEAR_BITS-1:0] YEAR_MAX      = '1;
    localparam logic [YEAR_BITS-1:0] EPOCH_YEAR    = YEAR_BITS'(1970);
    localparam logic [YEAR_BITS-1:0] FALLBACK_YEAR = YEAR_BITS'(2000);

    localparam logic [MONTH_BITS-1:0] MONTH_JAN = MONTH_BITS'(1);
    localparam logic [MONTH_BITS-1:0] MONTH_FEB = MONTH_BITS'(2);
    localparam logic [MONTH_BITS-1:0] MONTH_DEC = MONTH_BITS'(12);
    localparam logic [DAY_BITS-1:0]   DAY_FIRST = DAY_BITS'(1);
    localparam logic [DAY_BITS-1:0]   DEC_LEN   = DAY_BITS'(31);

    // x divisible by 25 <=> x * inv(25) mod 2^32 <= (2^32-1)/25
    localparam logic [31:0] INV25       = 32'hC28F_5C29;
    localparam logic [31:0] DIV25_LIMIT = 32'h0A3D_70A3;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_LOAD = 3'd0,
        KIND_NEXT = 3'd1,
        KIND_PREV = 3'd2,
        KIND_ADD  = 3'd3,
        KIND_SUB  = 3'd4
    } kind_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LOAD = 2'd1,
        ST_RANGE    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEAP,
        S_STEP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]   kind;
        logic [DAY_BITS-1:0]    load_day;
        logic [MONTH_BITS-1:0]  load_month;
        logic [FYEAR_BITS-1:0]  load_year;
        logic [FCOUNT_BITS-1:0] day_count;
    } item_t;

    typedef struct packed {
        logic [DAY_BITS-1:0]    cur_day;
        logic [MONTH_BITS-1:0]  cur_month;
        logic [FYEAR_BITS-1:0]  cur_year;
        logic [STATUS_BITS-1:0] status;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic start;    // capture accepted beat
        logic leap;     // refresh leap flag of working year
        logic step;     // one month step / check
        logic finish;   // commit and load result register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic done;        // step finishes the item
        logic year_moved;  // step changed the working year
    } stat_t;

    function automatic logic is_leap(input logic [YEAR_BITS-1:0] y);
        logic [31:0] prod;
        logic        div25;
        begin
            prod  = 32'(y) * INV25;
            div25 = (prod <= DIV25_LIMIT);
            return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
        end
    endfunction

    function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] m,
                                                      input logic                  leap);
        logic [DAY_BITS-1:0] len;
        begin
            case (m)
                MONTH_BITS'(2):  len = leap ? DAY_BITS'(29) : DAY_BITS'(28);
                MONTH_BITS'(4),
                MONTH_BITS'(6),
                MONTH_BITS'(9),
                MONTH_BITS'(11): len = DAY_BITS'(30);
                default:         len = DAY_BITS'(31);
            endcase
            return len;
        end
    endfunction

endpackage

// ===== hw/rtl/gda_if.sv =====
// Valid/ready channel interfaces for the date unit: item in, result out.
// Depends on gda_pkg for the payload types.
interface gda_item_if;
    logic            valid;
    logic            ready;
    gda_pkg::item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gda_result_if;
    logic             valid;
    logic             ready;
    gda_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/gda_ctrl.sv =====
// Sequencer for the date unit: accepts a beat, drives leap/step cycles, hands off result.
// Depends on gda_pkg.
module gda_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  gda_pkg::stat_t stat,
    output gda_pkg::cmd_t  cmd
);
    import gda_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_LEAP;
                end
            end
            S_LEAP:
            begin
                cmd.leap   = 1'b1;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                cmd.step = 1'b1;
                if (stat.done)
                    state_next = S_DONE;
                else if (stat.year_moved)
                    state_next = S_LEAP;
            end
            S_DONE:
            begin
                // result slot free or being emptied this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/gda_dp.sv =====
// Datapath of the date unit: current date, working date, month stepper, result register.
// Depends on gda_pkg.
module gda_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  gda_pkg::item_t   item,
    input  gda_pkg::cmd_t    cmd,
    output gda_pkg::stat_t   stat,
    output gda_pkg::result_t result
);
    import gda_pkg::*;

    // current date
    logic [DAY_BITS-1:0]   day_reg;
    logic [MONTH_BITS-1:0] month_reg;
    logic [YEAR_BITS-1:0]  year_reg;

    // working copy
    logic signed [WDAY_BITS-1:0] wd_reg, wd_next;
    logic [MONTH_BITS-1:0]       wm_reg, wm_next;
    logic [YEAR_BITS-1:0]        wy_reg, wy_next;
    logic                        leap_reg;
    logic [KIND_BITS-1:0]        kind_reg;
    logic [DAY_BITS-1:0]         ld_reg;
    logic                        ly_fits_reg;
    logic                        commit_reg, commit_next;
    status_t                     status_reg, status_next;
    result_t                     out_reg;

    logic [CNT_USE_BITS-1:0]     delta;
    logic signed [WDAY_BITS-1:0] day_ext;
    logic signed [WDAY_BITS-1:0] len_s;
    logic signed [WDAY_BITS-1:0] prev_len_s;
    logic [MONTH_BITS-1:0]       prev_m;
    logic                        load_ok;

    assign delta = ((item.kind == KIND_NEXT) || (item.kind == KIND_PREV))
                   ? CNT_USE_BITS'(1) : item.day_count[CNT_USE_BITS-1:0];
    assign day_ext    = $signed(WDAY_BITS'(day_reg));
    assign len_s      = $signed(WDAY_BITS'(month_len(wm_reg, leap_reg)));
    assign prev_m     = wm_reg - MONTH_BITS'(1);
    assign prev_len_s = $signed(WDAY_BITS'(month_len(prev_m, leap_reg)));
    assign load_ok    = (wm_reg >= MONTH_JAN) && (wm_reg <= MONTH_DEC) &&
                        (ld_reg != '0) && ly_fits_reg &&
                        (WDAY_BITS'(ld_reg) <= WDAY_BITS'(len_s));

    // one step of the month walk
    always_comb
    begin
        wd_next          = wd_reg;
        wm_next          = wm_reg;
        wy_next          = wy_reg;
        commit_next      = 1'b0;
        status_next      = ST_OK;
        stat.done        = 1'b0;
        stat.year_moved  = 1'b0;
        case (kind_reg)
            KIND_LOAD:
            begin
                stat.done   = 1'b1;
                commit_next = 1'b1;
                if (load_ok)
                    wd_next = $signed(WDAY_BITS'(ld_reg));
                else
                begin
                    wd_next     = $signed(WDAY_BITS'(DAY_FIRST));
                    wm_next     = MONTH_JAN;
                    wy_next     = FALLBACK_YEAR;
                    status_next = ST_BAD_LOAD;
                end
            end
            KIND_NEXT, KIND_ADD:
            begin
                if (wd_reg > len_s)
                begin
                    wd_next = wd_reg - len_s;
                    if (wm_reg == MONTH_DEC)
                    begin
                        if (wy_reg == YEAR_MAX)
                        begin
                            wd_next     = wd_reg;
                            stat.done   = 1'b1;
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            wm_next         = MONTH_JAN;
                            wy_next         = wy_reg + YEAR_BITS'(1);
                            stat.year_moved = 1'b1;
                        end
                    end
                    else
                        wm_next = wm_reg + MONTH_BITS'(1);
                end
                else
                begin
                    stat.done   = 1'b1;
                    commit_next = 1'b1;
                end
            end
            KIND_PREV, KIND_SUB:
            begin
                if (wd_reg < $signed(WDAY_BITS'(1)))
                begin
                    if (wm_reg == MONTH_JAN)
                    begin
                        if (wy_reg == '0)
                        begin
                            stat.done   = 1'b1;
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            // December has 31 days in any year
                            wm_next         = MONTH_DEC;
                            wy_next         = wy_reg - YEAR_BITS'(1);
                            wd_next         = wd_reg + $signed(WDAY_BITS'(DEC_LEN));
                            stat.year_moved = 1'b1;
                        end
                    end
                    else
                    begin
                        wm_next = prev_m;
                        wd_next = wd_reg + prev_len_s;
                    end
                end
                else
                begin
                    stat.done   = 1'b1;
                    commit_next = 1'b1;
                end
            end
            default:
                stat.done = 1'b1;   // unused kinds: report date as is
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_reg   <= DAY_FIRST;
            month_reg <= MONTH_JAN;
            year_reg  <= EPOCH_YEAR;
        end
        else if (cmd.finish && commit_reg)
        begin
            day_reg   <= wd_reg[DAY_BITS-1:0];
            month_reg <= wm_reg;
            year_reg  <= wy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            kind_reg    <= item.kind;
            ld_reg      <= item.load_day;
            ly_fits_reg <= (33'(item.load_year) <= 33'(YEAR_MAX));
            if (item.kind == KIND_LOAD)
            begin
                wd_reg <= day_ext;
                wm_reg <= item.load_month;
                wy_reg <= YEAR_BITS'(item.load_year);
            end
            else
            begin
                if ((item.kind == KIND_PREV) || (item.kind == KIND_SUB))
                    wd_reg <= day_ext - $signed(WDAY_BITS'(delta));
                else
                    wd_reg <= day_ext + $signed(WDAY_BITS'(delta));
                wm_reg <= month_reg;
                wy_reg <= year_reg;
            end
        end
        if (cmd.leap)
            leap_reg <= is_leap(wy_reg);
        if (cmd.step)
        begin
            wd_reg     <= wd_next;
            wm_reg     <= wm_next;
            wy_reg     <= wy_next;
            commit_reg <= commit_next;
            status_reg <= status_next;
        end
        if (cmd.finish)
        begin
            if (commit_reg)
            begin
                out_reg.cur_day   <= wd_reg[DAY_BITS-1:0];
                out_reg.cur_month <= wm_reg;
                out_reg.cur_year  <= FYEAR_BITS'(wy_reg);
            end
            else
            begin
                out_reg.cur_day   <= day_reg;
                out_reg.cur_month <= month_reg;
                out_reg.cur_year  <= FYEAR_BITS'(year_reg);
            end
            out_reg.status <= status_reg;
        end
    end

    assign result = out_reg;

endmodule

// ===== hw/rtl/gregorian_date_arithmetic.sv =====
// Gregorian date unit: one held date, load / next / previous / add / subtract per beat.
// Each beat goes IDLE, LEAP, STEP, DONE. Next/previous day and add/subtract walk the date
// one month per cycle in STEP, going back through LEAP for a leap refresh on each year
// crossed. One item in flight; the next beat is taken once the sequencer is back in IDLE,
// which it enters as the result register loads.
// Reset (async, active low) sets the date to 1970-01-01 and empties the result register.
module gregorian_date_arithmetic (
    input  logic         clk,
    input  logic         rst_n,
    gda_item_if.sink     item,
    gda_result_if.source result
);
    import gda_pkg::*;

    // Command and status between sequencer and datapath
    cmd_t    cmd;
    stat_t   stat;
    result_t dp_result;

    // Sequencer: IDLE takes a beat, LEAP computes the working year's leap flag,
    // STEP walks one month per cycle (back to LEAP on a year crossing),
    // DONE waits for the result register to be free, then commits.
    gda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: holds current date, working date, and the result register.
    // The result register lets the next beat enter while a result still waits.
    gda_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.data),
        .cmd    (cmd),
        .stat   (stat),
        .result (dp_result)
    );

    assign result.data = dp_result;

endmodule

// ===== hw/rtl/gda_checker.sv =====
// Port-level assertions for the date unit, bound to the top level.
// Depends on gda_pkg and gregorian_date_arithmetic.
module gda_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input gda_pkg::result_t out_data
);
    import gda_pkg::*;

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result changed while stalled");

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("beat accepted while busy");

    // every reported date has a nonzero day and a month from January to December
    a_date_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.cur_day != '0) && (out_data.cur_month >= MONTH_JAN) &&
                       (out_data.cur_month <= MONTH_DEC)))
        else $error("illegal date reported");

    // status code in range
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.status == ST_OK) || (out_data.status == ST_BAD_LOAD) ||
                       (out_data.status == ST_RANGE)))
        else $error("bad status code");

    // a rejected load reports the fallback date
    a_bad_load_date: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status == ST_BAD_LOAD)) |->
        ((out_data.cur_day == DAY_FIRST) && (out_data.cur_month == MONTH_JAN) &&
         (out_data.cur_year == FYEAR_BITS'(FALLBACK_YEAR))))
        else $error("bad load without fallback date");

endmodule

bind gregorian_date_arithmetic gda_checker u_gda_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);

// ===== tb/gregorian_date_arithmetic_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for gregorian_date_arithmetic: directed calendar corner cases, then
// random date traffic under source idling, sink stalls and a long sink hold-off.
// Depends on gda_pkg and the gda_item_if / gda_result_if channel interfaces.
module gregorian_date_arithmetic_test;
    import gda_pkg::*;

    // Kind codes the block decodes as no-ops
    localparam logic [KIND_BITS-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [KIND_BITS-1:0] KIND_SPARE_MID   = 3'd6;
    localparam logic [KIND_BITS-1:0] KIND_SPARE_LAST  = 3'd7;

    // Quiet cycles after the last result
    localparam int TAIL_CYCLES = 64;
    // Long sink hold-off, well past one beat in flight plus the result register
    localparam int HOLD_CYCLES = 400;

    logic clk = 1'b0;
    logic rst_n;

    gda_item_if   item_bus ();
    gda_result_if result_bus ();

    gregorian_date_arithmetic u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Calendar predictor: own copy of the held date, reset to the epoch.
    // ------------------------------------------------------------------
    longint cal_day   = 1;
    longint cal_month = 1;
    longint cal_year  = 1970;

    result_t expected_dates[$];
    result_t want;
    int      error_count    = 0;

    // Traffic shaping knobs, read by the sender task and the sink process
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_request   = 0;
    int stall_left     = 0;

    function automatic bit leap_year(input longint y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic longint days_in_month(input longint m, input longint y);
        if (m == MONTH_FEB)
            return leap_year(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    // Applies one beat to the predicted date and returns the result it should produce.
    // Range errors leave the held date as it was.
    function automatic result_t advance_calendar(input item_t beat);
        longint  d;
        longint  m;
        longint  y;
        longint  ylim;
        longint  step;
        bit      commit;
        status_t st;
        result_t r;
        d      = cal_day;
        m      = cal_month;
        y      = cal_year;
        ylim   = longint'(YEAR_MAX);
        step   = longint'(beat.day_count[CNT_USE_BITS-1:0]);
        commit = 1'b0;
        st     = ST_OK;
        case (beat.kind)
            KIND_LOAD:
            begin
                // day zero counts as invalid here
                if (beat.load_month < MONTH_JAN || beat.load_month > MONTH_DEC ||
                    beat.load_day < DAY_FIRST || longint'(beat.load_year) > ylim ||
                    beat.load_day > days_in_month(beat.load_month, beat.load_year))
                begin
                    d  = 1;
                    m  = MONTH_JAN;
                    y  = FALLBACK_YEAR;
                    st = ST_BAD_LOAD;
                end
                else
                begin
                    d = beat.load_day;
                    m = beat.load_month;
                    y = beat.load_year;
                end
                commit = 1'b1;
            end
            KIND_NEXT, KIND_ADD:
            begin
                d += (beat.kind == KIND_NEXT) ? 1 : step;
                commit = 1'b1;
                while (commit && d > days_in_month(m, y))
                begin
                    d -= days_in_month(m, y);
                    m++;
                    if (m > MONTH_DEC)
                    begin
                        m = MONTH_JAN;
                        if (y >= ylim)
                        begin
                            commit = 1'b0;
                            st     = ST_RANGE;
                        end
                        else
                            y++;
                    end
                end
            end
            KIND_PREV, KIND_SUB:
            begin
                d -= (beat.kind == KIND_PREV) ? 1 : step;
                commit = 1'b1;
                while (commit && d < 1)
                begin
                    m--;
                    if (m < MONTH_JAN)
                    begin
                        m = MONTH_DEC;
                        if (y == 0)
                        begin
                            commit = 1'b0;
                            st     = ST_RANGE;
                        end
                        else
                            y--;
                    end
                    if (commit)
                        d += days_in_month(m, y);
                end
            end
            default:
                ;   // spare kinds: report the held date, status ok
        endcase
        if (commit)
        begin
            cal_day   = d;
            cal_month = m;
            cal_year  = y;
        end
        r.cur_day   = DAY_BITS'(cal_day);
        r.cur_month = MONTH_BITS'(cal_month);
        r.cur_year  = FYEAR_BITS'(cal_year);
        r.status    = st;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $time, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Source side. The send task never lowers valid right after an accepted beat:
    // the next send keeps it high or drops it in its idle loop, or wait_for_results
    // drops it, so valid gets one nonblocking write per edge at most.
    // ------------------------------------------------------------------
    task automatic send_date_beat(input item_t beat);
        while ($urandom_range(99) < src_idle_pct)
        begin
            item_bus.valid <= 1'b0;
            @(posedge clk);
        end
        item_bus.valid <= 1'b1;
        item_bus.data  <= beat;
        do @(posedge clk); while (!item_bus.ready);
        expected_dates.push_back(advance_calendar(beat));
    endtask

    // Source pause: drop valid and wait until every predicted result is back.
    task automatic wait_for_results();
        item_bus.valid <= 1'b0;
        do @(posedge clk); while (expected_dates.size() != 0);
    endtask

    function automatic item_t date_beat(input logic [KIND_BITS-1:0] kind, input int d,
                                        input int m, input int y, input int cnt);
        item_t b;
        b.kind       = kind;
        b.load_day   = DAY_BITS'(d);
        b.load_month = MONTH_BITS'(m);
        b.load_year  = FYEAR_BITS'(y);
        b.day_count  = FCOUNT_BITS'(cnt);
        return b;
    endfunction

    // Random beat: mostly well-formed loads and date ops, some garbage loads and spare
    // kinds. All fields but day_count start fully random so every bit toggles even where ignored.
    function automatic item_t random_beat();
        item_t b;
        int    sel;
        int    m;
        int    y;
        b.kind       = KIND_BITS'($urandom);
        b.load_day   = DAY_BITS'($urandom);
        b.load_month = MONTH_BITS'($urandom);
        b.load_year  = FYEAR_BITS'($urandom);
        sel = $urandom_range(99);
        if (sel < 15)
        begin
            // legal load; years near either end now and then to provoke range errors
            m = $urandom_range(12, 1);
            case ($urandom_range(9))
                0:       y = $urandom_range(3);
                1:       y = $urandom_range(65535, 65532);
                default: y = $urandom_range(65535);
            endcase
            b = date_beat(KIND_LOAD, $urandom_range(days_in_month(m, y), 1), m, y, 0);
        end
        else if (sel < 22)
            b.kind = KIND_LOAD;
        else if (sel < 42)
            b.kind = KIND_NEXT;
        else if (sel < 62)
            b.kind = KIND_PREV;
        else if (sel < 78)
            b.kind = KIND_ADD;
        else if (sel < 94)
            b.kind = KIND_SUB;
        else
            b.kind = KIND_BITS'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
        // counts mostly small: a full 16-bit count walks ~2200 months
        sel = $urandom_range(99);
        if (sel < 65)
            b.day_count = FCOUNT_BITS'($urandom_range(60));
        else if (sel < 88)
            b.day_count = FCOUNT_BITS'($urandom_range(1500));
        else if (sel < 97)
            b.day_count = FCOUNT_BITS'($urandom_range(20000));
        else
            b.day_count = FCOUNT_BITS'($urandom_range(65535));
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Sink side: random stalls, plus a hold-off counted down here.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            stall_left   = hold_request;
            hold_request = 0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            result_bus.ready <= 1'b0;
        end
        else
            result_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Result checker: every accepted beat against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (expected_dates.size() == 0)
                report_mismatch($sformatf("unexpected result %0d-%0d-%0d st %0d",
                    result_bus.data.cur_year, result_bus.data.cur_month,
                    result_bus.data.cur_day, result_bus.data.status));
            else
            begin
                want = expected_dates.pop_front();
                if (result_bus.data.cur_day !== want.cur_day)
                    report_mismatch($sformatf("cur_day %0d, want %0d",
                        result_bus.data.cur_day, want.cur_day));
                if (result_bus.data.cur_month !== want.cur_month)
                    report_mismatch($sformatf("cur_month %0d, want %0d",
                        result_bus.data.cur_month, want.cur_month));
                if (result_bus.data.cur_year !== want.cur_year)
                    report_mismatch($sformatf("cur_year %0d, want %0d",
                        result_bus.data.cur_year, want.cur_year));
                if (result_bus.data.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                        result_bus.data.status, want.status));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Spare kind straight out of reset shows the epoch date
    task automatic test_reset_date();
        send_date_beat(date_beat(KIND_SPARE_LAST, 0, 0, 0, 0));
    endtask

    task automatic test_load_checks();
        send_date_beat(date_beat(KIND_LOAD, 29, 2, 2024, 0));     // leap year Feb 29
        send_date_beat(date_beat(KIND_LOAD, 29, 2, 2023, 0));     // common year Feb 29
        send_date_beat(date_beat(KIND_LOAD, 29, 2, 1900, 0));     // century, not leap
        send_date_beat(date_beat(KIND_LOAD, 29, 2, 2000, 0));     // 400-year leap
        send_date_beat(date_beat(KIND_LOAD, 0, 5, 2021, 0));      // day zero
        send_date_beat(date_beat(KIND_LOAD, 1, 0, 2021, 0));      // month zero
        send_date_beat(date_beat(KIND_LOAD, 31, 15, 65535, 0));   // month past December
        send_date_beat(date_beat(KIND_LOAD, 31, 4, 2021, 0));     // 30-day month overrun
        send_date_beat(date_beat(KIND_LOAD, 31, 12, 0, 0));       // year zero
    endtask

    // Single-day steps across month, leap-day and year boundaries
    task automatic test_day_steps();
        send_date_beat(date_beat(KIND_LOAD, 28, 2, 2024, 0));
        send_date_beat(date_beat(KIND_NEXT, 0, 0, 0, 0));
        send_date_beat(date_beat(KIND_NEXT, 0, 0, 0, 0));
        send_date_beat(date_beat(KIND_PREV, 0, 0, 0, 0));
        send_date_beat(date_beat(KIND_LOAD, 31, 12, 2023, 0));
        send_date_beat(date_beat(KIND_NEXT, 0, 0, 0, 0));
        send_date_beat(date_beat(KIND_PREV, 0, 0, 0, 0));
    endtask

    // Year overflow and underflow keep the date; zero counts are no-ops
    task automatic test_year_limits();
        send_date_beat(date_beat(KIND_LOAD, 31, 12, 65535, 0));
        send_date_beat(date_beat(KIND_NEXT, 0, 0, 0, 0));
        send_date_beat(date_beat(KIND_ADD, 0, 0, 0, 1));
        send_date_beat(date_beat(KIND_ADD, 0, 0, 0, 0));
        send_date_beat(date_beat(KIND_LOAD, 1, 1, 0, 0));
        send_date_beat(date_beat(KIND_PREV, 0, 0, 0, 0));
        send_date_beat(date_beat(KIND_SUB, 0, 0, 0, 65535));
        send_date_beat(date_beat(KIND_SUB, 0, 0, 0, 0));
    endtask

    // Largest count both ways, then the remaining spare kinds
    task automatic test_long_counts();
        send_date_beat(date_beat(KIND_ADD, 31, 15, 65535, 65535));
        send_date_beat(date_beat(KIND_SUB, 0, 0, 0, 65535));
        send_date_beat(date_beat(KIND_SPARE_FIRST, 0, 0, 0, 0));
        send_date_beat(date_beat(KIND_SPARE_MID, 0, 0, 0, 0));
    endtask

    // Sink holds off while the source keeps offering; input must stall, nothing lost.
    // Afterwards the source pauses until the block is empty.
    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_request   = HOLD_CYCLES;
        repeat (12) send_date_beat(random_beat());
        wait_for_results();
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct, input int beats);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (beats) send_date_beat(random_beat());
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, 57);       // back to back
        run_random_phase(65, 0, 57);      // source gaps
        run_random_phase(0, 65, 57);      // sink stalls
        run_random_phase(32, 32, 57);     // both
    endtask

    // Run limit: worst case is far below this even if every beat took a full count
    initial
    begin
        #50ms;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n            = 1'b0;
        item_bus.valid   = 1'b0;
        item_bus.data    = '0;
        result_bus.ready = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_date();
        test_load_checks();
        test_day_steps();
        test_year_limits();
        test_long_counts();
        test_backpressure();
        test_random_traffic();

        // drain, then watch for stray results
        wait_for_results();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== gregorian_date_arithmetic.f =====
hw/rtl/gda_pkg.sv
hw/rtl/gda_if.sv
hw/rtl/gda_ctrl.sv
hw/rtl/gda_dp.sv
hw/rtl/gregorian_date_arithmetic.sv
hw/rtl/gda_checker.sv
tb/gregorian_date_arithmetic_test.sv
